### hw/rtl/nds_pkg.sv
`timescale 1ns / 1ps

package nds_pkg;

    localparam int DIGIT_W   = 4;
    localparam int CODE_W    = 10;
    localparam int WORD_W    = 64;
    localparam int NIB_W     = 4;
    localparam int NIB_COUNT = WORD_W / NIB_W;
    localparam int CNT_W     = $clog2(NIB_COUNT);
    localparam int IN_W      = 6 * DIGIT_W;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [CODE_W-1:0] CODE_BLANK = 10'h3FF;
    localparam logic [CODE_W-1:0] CODE_ZERO  = 10'h3FE;
    localparam logic [NIB_W-1:0]  TAIL_BITS  = 4'hF;
    localparam logic [CNT_W-1:0]  LAST_NIB   = CNT_W'(NIB_COUNT - 1);

    typedef logic [WORD_W-1:0] word_t;

    // one packed display word moving between stages
    typedef struct packed {
        logic  valid;
        word_t word;
    } word_req_t;

    // active-low one-hot tube code; ten reads as zero, above ten blanks
    function automatic logic [CODE_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
        logic [CODE_W-1:0] code;
        code = CODE_BLANK;
        if (d == 4'd0 || d == 4'd10) begin
            code = CODE_ZERO;
        end else if (d inside {[4'd1:4'd9]}) begin
            code = ~(CODE_W'(1) << (4'd10 - d));
        end
        return code;
    endfunction

endpackage

### hw/rtl/nixie_digit_serializer_unit.sv
`timescale 1ns / 1ps

// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata[23:0]: six tube digits
// m_      | out | m_tvalid/m_tready  | m_tdata[3:0]: lane bits, m_tlast: latch
//
// One request in gives sixteen nibble requests out, low word nibble first.
// The nibble shifter sends one nibble per cycle while m_tready is high and loads
// the next word as the last leaves; a request passes decoder register and queue.
// Decoder register and a two-word queue absorb upstream requests while the
// shifter drains, so a back-pressured output does not stall input at once.
// Reset (aresetn, synchronous, active low) empties every stage.

module nixie_digit_serializer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // hour_tens[3:0], hour_units[7:4], minute_tens[11:8], minute_units[15:12],
    // second_tens[19:16], second_units[23:20]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // lane_four_bit[0], lane_three_bit[1], lane_two_bit[2], lane_one_bit[3],
    // bits 7:4 zero
    output logic [7:0]  m_tdata,
    // latch_now: high on the sixteenth nibble of a word
    output logic        m_tlast
);
    import nds_pkg::*;

    word_req_t         dec_req, q_req;
    logic              q_push_ready, back_ready;
    logic [NIB_W-1:0]  nib;

    // front: decode digits into the 64-bit tube word
    nds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_digits (s_tdata[IN_W-1:0]),
        .out_req   (dec_req),
        .out_ready (q_push_ready)
    );

    // decoupling queue between decoder and shifter
    nds_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_req   (dec_req),
        .push_ready (q_push_ready),
        .pop_req    (q_req),
        .pop_ready  (back_ready)
    );

    // back: nibble shifter, LSB nibble first
    nds_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_req    (q_req),
        .in_ready  (back_ready),
        .nib_valid (m_tvalid),
        .nib_ready (m_tready),
        .nib_data  (nib),
        .nib_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, nib};

endmodule

### hw/rtl/nds_front.sv
`timescale 1ns / 1ps

module nds_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [nds_pkg::IN_W-1:0]  in_digits,
    output nds_pkg::word_req_t        out_req,
    input  logic                      out_ready
);
    import nds_pkg::*;

    logic  valid_reg, valid_next;
    word_t word_reg, word_next;
    word_t decoded;

    // digit 0 sits in the lowest nibble and lands at the top of the word
    assign decoded = {digit_code(in_digits[3:0]),   digit_code(in_digits[7:4]),
                      digit_code(in_digits[11:8]),  digit_code(in_digits[15:12]),
                      digit_code(in_digits[19:16]), digit_code(in_digits[23:20]),
                      TAIL_BITS};

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                word_next = decoded;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        word_reg <= word_next;
    end

    assign out_req.valid = valid_reg;
    assign out_req.word  = word_reg;

endmodule

### hw/rtl/nds_queue.sv
`timescale 1ns / 1ps

module nds_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  nds_pkg::word_req_t push_req,
    output logic               push_ready,
    output nds_pkg::word_req_t pop_req,
    input  logic               pop_ready
);
    import nds_pkg::*;

    word_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                push, pop;

    assign push_ready    = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_req.valid = cnt_reg != '0;
    assign pop_req.word  = mem_reg[rd_ptr_reg];

    assign push = push_req.valid && push_ready;
    assign pop  = pop_req.valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req.word;
        end
    end

endmodule

### hw/rtl/nds_back.sv
`timescale 1ns / 1ps

module nds_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  nds_pkg::word_req_t        in_req,
    output logic                      in_ready,
    output logic                      nib_valid,
    input  logic                      nib_ready,
    output logic [nds_pkg::NIB_W-1:0] nib_data,
    output logic                      nib_last
);
    import nds_pkg::*;

    logic              busy_reg, busy_next;
    word_t             word_reg, word_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              take, at_last;

    assign at_last = cnt_reg == LAST_NIB;
    // reload when empty or as the final nibble leaves
    assign take     = !busy_reg || (nib_ready && at_last);
    assign in_ready = take;

    always_comb begin
        busy_next = busy_reg;
        word_next = word_reg;
        cnt_next  = cnt_reg;
        if (take) begin
            busy_next = in_req.valid;
            word_next = in_req.word;
            cnt_next  = '0;
        end else if (nib_ready) begin
            word_next = {NIB_W'(0), word_reg[WORD_W-1:NIB_W]};
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        word_reg <= word_next;
    end

    assign nib_valid = busy_reg;
    assign nib_data  = word_reg[NIB_W-1:0];
    assign nib_last  = at_last;

endmodule
